// File: src/aesp_pkg.sv
// ----------------------------------------------------------------------------
// aesp_pkg: shared types and constants for the escape sequence parser
// Holds the parser and sequencer state types, the byte codes the parser
// recognizes, the attribute constants and the color-code update function.
// ----------------------------------------------------------------------------
package aesp_pkg;

  // Parser states, one code per point in an ESC [ sequence.
  typedef enum logic [3:0] {
    PS_INIT    = 4'd0,
    PS_ESC     = 4'd1,
    PS_BRACE   = 4'd2,
    PS_SAVE    = 4'd3,
    PS_RESTORE = 4'd4,
    PS_CLEAR   = 4'd5,
    PS_ERASE   = 4'd6,
    PS_DIGIT   = 4'd7,
    PS_UP      = 4'd8,
    PS_DOWN    = 4'd9,
    PS_FWD     = 4'd10,
    PS_BACK    = 4'd11,
    PS_COLOR   = 4'd12,
    PS_SEMI    = 4'd13
  } ps_t;

  // Sequencer states: waiting for a byte, or working on the one held.
  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_RUN  = 1'b1
  } seq_t;

  // Byte codes.
  localparam logic [7:0] CH_ESC     = 8'h1b;
  localparam logic [7:0] CH_LBRACK  = 8'h5b;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_TWO     = 8'h32;
  localparam logic [7:0] CH_SEMI    = 8'h3b;
  localparam logic [7:0] CH_UP      = 8'h41;
  localparam logic [7:0] CH_DOWN    = 8'h42;
  localparam logic [7:0] CH_FWD     = 8'h43;
  localparam logic [7:0] CH_BACK    = 8'h44;
  localparam logic [7:0] CH_ERASE   = 8'h4b;
  localparam logic [7:0] CH_COLOR   = 8'h6d;
  localparam logic [7:0] CH_SAVE    = 8'h73;
  localparam logic [7:0] CH_RESTORE = 8'h75;

  // Attribute constants.
  localparam logic [15:0] ATTR_RESET = 16'h0700;
  localparam logic [15:0] ATTR_BLINK = 16'h8000;
  localparam logic [15:0] FG_MASK    = 16'h0700;
  localparam logic [15:0] BG_MASK    = 16'h7000;

  // Select graphic rendition codes.
  localparam logic [7:0] SGR_RESET = 8'd0;
  localparam logic [7:0] SGR_BLINK = 8'd5;
  localparam logic [7:0] SGR_FG_LO = 8'd30;
  localparam logic [7:0] SGR_FG_HI = 8'd37;
  localparam logic [7:0] SGR_BG_LO = 8'd40;
  localparam logic [7:0] SGR_BG_HI = 8'd47;

  // Applies one color code to an attribute word; unknown codes leave it alone.
  function automatic logic [15:0] apply_sgr(input logic [15:0] attr, input logic [7:0] v);
    logic [15:0] res;
    logic [7:0]  fg;
    logic [7:0]  bg;
    res = attr;
    fg  = v - SGR_FG_LO;
    bg  = v - SGR_BG_LO;
    if (v == SGR_RESET) begin
      res = ATTR_RESET;
    end else if (v == SGR_BLINK) begin
      res = attr | ATTR_BLINK;
    end else if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
      res = (attr & ~FG_MASK) | {5'b0, fg[2:0], 8'b0};
    end else if (v >= SGR_BG_LO && v <= SGR_BG_HI) begin
      res = (attr & ~BG_MASK) | {1'b0, bg[2:0], 12'b0};
    end
    return res;
  endfunction

endpackage

// File: src/ansi_escape_sequence_parser.sv
// ----------------------------------------------------------------------------
// ansi_escape_sequence_parser: console escape sequence parser
// Parses ESC [ sequences byte by byte, keeps the text attribute and a saved
// copy, moves the cursor and flags screen or line clears.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Payload
// s_axis    in         char_in, cursor_in
// m_axis    out        attribute, cursor_out, clear_screen, clear_line, idle
//
// Each byte is accepted in the idle state and then run through the parser
// step in the run state. For the byte after a color command, the color walk
// first applies the stored parameters over the shared read port, one entry a
// cycle. The result waits in an output register; the step is only committed
// once that register is free, so a stalled output holds the parser.
// Synchronous reset returns the parser to its initial state with the default
// attribute; the block is ready for a byte as soon as reset is released.
//
module ansi_escape_sequence_parser #(
  parameter int MAX_PARAMS   = 8,
  parameter int SCREEN_COLS  = 80,
  parameter int SCREEN_CELLS = 2000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // char_in[7:0], cursor_in[18:8], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // attribute[15:0], cursor_out[26:16],
                                      // clear_screen[27], clear_line[28],
                                      // idle[29], zero fill
);

  localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int CNT_W = $clog2(MAX_PARAMS + 1);
  localparam int POS_W = 17;

  // Registers.
  aesp_pkg::seq_t    seq, seq_next;
  aesp_pkg::ps_t     pstate, pstate_next;
  logic [7:0]        param_values [MAX_PARAMS];
  logic [IDX_W-1:0]  param_index, param_index_next;
  logic [CNT_W-1:0]  param_count, param_count_next;
  logic [CNT_W-1:0]  walk_idx, walk_idx_next;
  logic [15:0]       current_attr, current_attr_next;
  logic [15:0]       saved_attr, saved_attr_next;
  logic [7:0]        char_r, char_r_next;
  logic [10:0]       cursor_r, cursor_r_next;
  logic              out_valid, out_valid_next;
  logic [31:0]       out_data, out_data_next;

  // Parameter register write controls.
  logic              pv_clear;
  logic              pv_we;
  logic [IDX_W-1:0]  pv_waddr;
  logic [7:0]        pv_wdata;

  // Shared datapath signals.
  logic              is_digit;
  logic [CNT_W-1:0]  idx_inc;
  logic [IDX_W-1:0]  semi_idx;
  logic [CNT_W-1:0]  semi_cnt;
  logic [CNT_W-1:0]  cnt_inc;
  logic [IDX_W-1:0]  acc_slot;
  logic [IDX_W-1:0]  rd_addr;
  logic [7:0]        rd_val;
  logic [7:0]        mac;
  logic [POS_W-1:0]  pos_w;
  logic [POS_W-1:0]  cols_w;
  logic [10:0]       pos;
  logic              cls;
  logic              cll;

  assign s_axis_tready = (seq == aesp_pkg::SEQ_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Digit test, and index and count advance for a semicolon.
  always_comb begin
    is_digit = (char_r >= aesp_pkg::CH_ZERO) && (char_r <= aesp_pkg::CH_NINE);
    idx_inc  = CNT_W'(param_index) + CNT_W'(1);
    cnt_inc  = (param_count < CNT_W'(MAX_PARAMS)) ? param_count + CNT_W'(1) : param_count;
    if (idx_inc < CNT_W'(MAX_PARAMS)) begin
      semi_idx = idx_inc[IDX_W-1:0];
      semi_cnt = cnt_inc;
    end else begin
      semi_idx = '0;
      semi_cnt = param_count;
    end
  end

  // One read port into the parameter registers, shared by the decimal
  // accumulator and the color walk; also the widened cursor and column width.
  always_comb begin
    acc_slot = (pstate == aesp_pkg::PS_SEMI) ? semi_idx : param_index;
    rd_addr  = (pstate == aesp_pkg::PS_COLOR) ? walk_idx[IDX_W-1:0] : acc_slot;
    rd_val   = param_values[rd_addr];
    mac      = 8'({rd_val, 3'b0}) + 8'({rd_val, 1'b0}) + {4'b0, char_r[3:0]};
    pos_w    = {6'b0, cursor_r};
    cols_w   = POS_W'(SCREEN_COLS);
  end

  // Sequencer and parser step.
  always_comb begin
    seq_next          = seq;
    pstate_next       = pstate;
    param_index_next  = param_index;
    param_count_next  = param_count;
    walk_idx_next     = walk_idx;
    current_attr_next = current_attr;
    saved_attr_next   = saved_attr;
    char_r_next       = char_r;
    cursor_r_next     = cursor_r;
    out_valid_next    = out_valid && !m_axis_tready;
    out_data_next     = out_data;
    pv_clear          = 1'b0;
    pv_we             = 1'b0;
    pv_waddr          = acc_slot;
    pv_wdata          = mac;
    pos               = cursor_r;
    cls               = 1'b0;
    cll               = 1'b0;

    case (seq)
      aesp_pkg::SEQ_IDLE: begin
        if (s_axis_tvalid) begin
          char_r_next   = s_axis_tdata[7:0];
          cursor_r_next = s_axis_tdata[18:8];
          walk_idx_next = '0;
          seq_next      = aesp_pkg::SEQ_RUN;
        end
      end
      aesp_pkg::SEQ_RUN: begin
        if (pstate == aesp_pkg::PS_COLOR && walk_idx < param_count) begin
          // Color walk: one stored code per cycle.
          current_attr_next = aesp_pkg::apply_sgr(current_attr, rd_val);
          walk_idx_next     = walk_idx + CNT_W'(1);
        end else if (!out_valid || m_axis_tready) begin
          pstate_next = aesp_pkg::PS_INIT;
          case (pstate)
            aesp_pkg::PS_INIT: begin
              pv_clear         = 1'b1;
              param_index_next = '0;
              param_count_next = '0;
              if (char_r == aesp_pkg::CH_ESC) begin
                pstate_next = aesp_pkg::PS_ESC;
              end
            end
            aesp_pkg::PS_ESC: begin
              if (char_r == aesp_pkg::CH_LBRACK) begin
                pstate_next = aesp_pkg::PS_BRACE;
              end
            end
            aesp_pkg::PS_BRACE: begin
              if (is_digit) begin
                pv_we            = 1'b1;
                param_count_next = cnt_inc;
                pstate_next      = (char_r == aesp_pkg::CH_TWO) ? aesp_pkg::PS_CLEAR
                                                                : aesp_pkg::PS_DIGIT;
              end else if (char_r == aesp_pkg::CH_ERASE) begin
                pstate_next = aesp_pkg::PS_ERASE;
              end else if (char_r == aesp_pkg::CH_RESTORE) begin
                pstate_next = aesp_pkg::PS_RESTORE;
              end else if (char_r == aesp_pkg::CH_SAVE) begin
                pstate_next = aesp_pkg::PS_SAVE;
              end
            end
            aesp_pkg::PS_SAVE: begin
              saved_attr_next = current_attr;
            end
            aesp_pkg::PS_RESTORE: begin
              current_attr_next = saved_attr;
            end
            aesp_pkg::PS_CLEAR: begin
              cls = 1'b1;
            end
            aesp_pkg::PS_ERASE: begin
              cll = 1'b1;
            end
            aesp_pkg::PS_DIGIT: begin
              if (is_digit) begin
                pv_we       = 1'b1;
                pstate_next = aesp_pkg::PS_DIGIT;
              end else if (char_r == aesp_pkg::CH_SEMI) begin
                pstate_next = aesp_pkg::PS_SEMI;
              end else if (char_r == aesp_pkg::CH_UP) begin
                pstate_next = aesp_pkg::PS_UP;
              end else if (char_r == aesp_pkg::CH_DOWN) begin
                pstate_next = aesp_pkg::PS_DOWN;
              end else if (char_r == aesp_pkg::CH_FWD) begin
                pstate_next = aesp_pkg::PS_FWD;
              end else if (char_r == aesp_pkg::CH_BACK) begin
                pstate_next = aesp_pkg::PS_BACK;
              end else if (char_r == aesp_pkg::CH_COLOR) begin
                pstate_next = aesp_pkg::PS_COLOR;
              end
            end
            aesp_pkg::PS_UP: begin
              if (pos_w > cols_w) begin
                pos = 11'(pos_w - cols_w);
              end
            end
            aesp_pkg::PS_DOWN: begin
              if (pos_w + cols_w < POS_W'(SCREEN_CELLS)) begin
                pos = 11'(pos_w + cols_w);
              end
            end
            aesp_pkg::PS_FWD: begin
              if (pos_w < cols_w) begin
                pos = cursor_r + 11'd1;
              end
            end
            aesp_pkg::PS_BACK: begin
              if (cursor_r != 11'd0) begin
                pos = cursor_r - 11'd1;
              end
            end
            aesp_pkg::PS_COLOR: begin
              // The walk has already brought the attribute up to date.
            end
            aesp_pkg::PS_SEMI: begin
              param_index_next = semi_idx;
              param_count_next = semi_cnt;
              if (is_digit) begin
                pv_we       = 1'b1;
                pstate_next = aesp_pkg::PS_DIGIT;
              end else if (char_r == aesp_pkg::CH_COLOR) begin
                pstate_next = aesp_pkg::PS_COLOR;
              end
            end
            default: begin
              pstate_next = aesp_pkg::PS_INIT;
            end
          endcase
          out_valid_next = 1'b1;
          out_data_next  = {2'b0, (pstate_next == aesp_pkg::PS_INIT), cll, cls, pos,
                            current_attr_next};
          seq_next       = aesp_pkg::SEQ_IDLE;
        end
      end
      default: begin
        seq_next = aesp_pkg::SEQ_IDLE;
      end
    endcase
  end

  // Control and attribute registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq          <= aesp_pkg::SEQ_IDLE;
      pstate       <= aesp_pkg::PS_INIT;
      param_index  <= '0;
      param_count  <= '0;
      walk_idx     <= '0;
      current_attr <= aesp_pkg::ATTR_RESET;
      saved_attr   <= aesp_pkg::ATTR_RESET;
      out_valid    <= 1'b0;
    end else begin
      seq          <= seq_next;
      pstate       <= pstate_next;
      param_index  <= param_index_next;
      param_count  <= param_count_next;
      walk_idx     <= walk_idx_next;
      current_attr <= current_attr_next;
      saved_attr   <= saved_attr_next;
      out_valid    <= out_valid_next;
    end
  end

  // Parameter registers: cleared together, written one slot at a time.
  always_ff @(posedge clk) begin
    if (rst || pv_clear) begin
      for (int i = 0; i < MAX_PARAMS; i++) begin
        param_values[i] <= 8'd0;
      end
    end else if (pv_we) begin
      param_values[pv_waddr] <= pv_wdata;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    char_r   <= char_r_next;
    cursor_r <= cursor_r_next;
    out_data <= out_data_next;
  end

endmodule
